// ===== rtl/weekday_alarm_table_matcher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Weekday alarm table matcher assertion macros
// Immediate-consequence and next-cycle property checks, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef WEEKDAY_ALARM_TABLE_MATCHER_UNIT_MACROS_SVH
`define WEEKDAY_ALARM_TABLE_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define WAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define WAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WAT_ASSERT_NOW(lbl, ante, cons, msg)
`define WAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/wat_pkg.sv =====
// ----------------------------------------------------------------------------
// Weekday alarm table package
// Word types, entry layout and request and status codes
// ----------------------------------------------------------------------------
package wat_pkg;

  localparam int DEF_ALARM_ENTRIES = 64;
  localparam int IDX_W             = 6;
  localparam int CNT_OUT_W         = 7;

  typedef enum logic [1:0] {
    REQ_CHECK = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_DEL   = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [6:0] day_mask;
    logic [5:0] entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       alarm_hit;
    logic [5:0] checked_index;
    logic [6:0] alarm_count;
    logic [4:0] read_hour;
    logic [5:0] read_minute;
    logic [6:0] read_mask;
  } out_word_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
  } entry_t;

endpackage

// ===== rtl/wat_match.sv =====
// ----------------------------------------------------------------------------
// Weekday alarm entry match
// Compares one stored entry with the current time and day of week
// ----------------------------------------------------------------------------
module wat_match import wat_pkg::*; (
  input  entry_t     entry_i,
  input  logic [4:0] hour_i,
  input  logic [5:0] minute_i,
  input  logic [5:0] second_i,
  input  logic [2:0] weekday_i,
  output logic       hit_o
);

  logic [2:0] day_bit;

  // day 0 counts as saturday
  assign day_bit = (weekday_i == 3'd0) ? 3'd6 : (weekday_i - 3'd1);

  assign hit_o = entry_i.mask[day_bit] && (entry_i.hour == hour_i) &&
                 (entry_i.minute == minute_i) && (second_i > 6'd1);

endmodule

// ===== rtl/weekday_alarm_table_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Weekday alarm table matcher
// Check and read pass IDLE, READ, RESP; add, range errors, an empty-table check and
// deleting the last entry pass IDLE, RESP; other deletes move later entries down
// in SHIFT. One word at a time; RESP waits for out_ready_i.
// Reset empties the table and zeroes the scan position; no clearing pass.
// ----------------------------------------------------------------------------
`include "weekday_alarm_table_matcher_unit_macros.svh"

module weekday_alarm_table_matcher_unit import wat_pkg::*; #(
  parameter int ALARM_ENTRIES = DEF_ALARM_ENTRIES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int CW = $clog2(ALARM_ENTRIES + 1);
  localparam int AW = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;
  localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]    state_q, state_d;
  in_word_t      req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] wr_ptr_q, wr_ptr_d;
  out_word_t     pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;

  entry_t        mem [ALARM_ENTRIES];
  entry_t        rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  logic [CW-1:0] ptr_eff;
  logic [XW-1:0] ptr_w, idx_w, idx_p1, cnt_w;
  logic [CW:0]   shift_nxt;
  logic          hit;

  wat_match u_match (
    .entry_i   (rdata_q),
    .hour_i    (req_q.hour),
    .minute_i  (req_q.minute),
    .second_i  (req_q.second),
    .weekday_i (req_q.weekday),
    .hit_o     (hit)
  );

  // scan restarts at the top once it runs past the end
  assign ptr_eff   = (scan_q >= count_q) ? '0 : scan_q;
  assign ptr_w     = XW'(ptr_eff);
  assign idx_w     = XW'(in_word_i.entry_index);
  assign idx_p1    = idx_w + XW'(1);
  assign cnt_w     = XW'(count_q);
  assign shift_nxt = {1'b0, wr_ptr_q} + (CW+1)'(2);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    scan_d      = scan_q;
    wr_ptr_d    = wr_ptr_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_word_i;
          pend_d  = '0;
          state_d = S_RESP;
          case (req_e'(in_word_i.req_type))
            REQ_CHECK: begin
              if (count_q == '0) begin
                scan_d = '0;
              end else begin
                mem_re               = 1'b1;
                mem_raddr            = ptr_eff[AW-1:0];
                scan_d               = ptr_eff + CW'(1);
                pend_d.checked_index = ptr_w[IDX_W-1:0];
                state_d              = S_READ;
              end
            end
            REQ_ADD: begin
              if (count_q >= CW'(ALARM_ENTRIES)) begin
                pend_d.status = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = count_q[AW-1:0];
                mem_wdata.hour   = in_word_i.hour;
                mem_wdata.minute = in_word_i.minute;
                mem_wdata.mask   = in_word_i.day_mask;
                count_d          = count_q + CW'(1);
              end
            end
            REQ_DEL: begin
              if (idx_w >= cnt_w) begin
                pend_d.status = ST_RANGE;
              end else if (idx_p1 < cnt_w) begin
                mem_re    = 1'b1;
                mem_raddr = idx_p1[AW-1:0];
                wr_ptr_d  = idx_w[CW-1:0];
                state_d   = S_SHIFT;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            REQ_READ: begin
              if (idx_w >= cnt_w) begin
                pend_d.status = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_w[AW-1:0];
                state_d   = S_READ;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_READ: begin
        if (req_e'(req_q.req_type) == REQ_CHECK) begin
          pend_d.alarm_hit = hit;
        end else begin
          pend_d.read_hour   = rdata_q.hour;
          pend_d.read_minute = rdata_q.minute;
          pend_d.read_mask   = rdata_q.mask;
        end
        state_d = S_RESP;
      end
      S_SHIFT: begin
        // entry below takes the one just read, next read runs two ahead
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q[AW-1:0];
        mem_wdata = rdata_q;
        wr_ptr_d  = wr_ptr_q + CW'(1);
        if (shift_nxt < {1'b0, count_q}) begin
          mem_re    = 1'b1;
          mem_raddr = shift_nxt[AW-1:0];
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = pend_q;
          out_d.alarm_count = cnt_w[CNT_OUT_W-1:0];
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    wr_ptr_q <= wr_ptr_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  // alarm table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  `WAT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(ALARM_ENTRIES), "count above table size")
  `WAT_ASSERT_NOW(a_shift_in_table, state_q == S_SHIFT, ({1'b0, wr_ptr_q} + (CW+1)'(1)) < {1'b0, count_q}, "shift past last entry")
  `WAT_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o, "accepted word left block idle")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Weekday alarm table matcher testbench
// Runs directed and random requests through valid/ready handshakes, both sides
// idling at random in all but the last load. A scoreboard tracks the alarm table,
// its fill level and its scan position, predicts every reply word and compares it
// field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wat_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_LOAD = 600;
  localparam int DRAIN_CYCLES   = 80;

  typedef enum int {FILL_BURST, MIXED_BURST, DRAIN_BURST} burst_e;

  class alarm_table_tracker;
    entry_t      slots [DEF_ALARM_ENTRIES];
    int unsigned fill;
    int unsigned scan_pos;
    out_word_t   pending [$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned replies;
    int unsigned hits;
    int unsigned fulls;
    int unsigned ranges;

    function int unsigned next_scan();
      return (scan_pos >= fill) ? 0 : scan_pos;
    endfunction

    function void note_request(in_word_t w);
      out_word_t   r;
      int unsigned day_bit;
      r = '0;
      requests++;
      case (w.req_type)
        REQ_CHECK: begin
          if (scan_pos >= fill) scan_pos = 0;
          if (fill > 0) begin
            day_bit = (w.weekday == 3'd0) ? 6 : w.weekday - 1;
            r.checked_index = IDX_W'(scan_pos);
            r.alarm_hit = slots[scan_pos].mask[day_bit] && slots[scan_pos].hour == w.hour &&
                          slots[scan_pos].minute == w.minute && w.second > 6'd1;
            hits += r.alarm_hit;
            scan_pos++;
          end
        end
        REQ_ADD: begin
          if (fill >= DEF_ALARM_ENTRIES) begin
            r.status = ST_FULL;
            fulls++;
          end else begin
            slots[fill] = {w.hour, w.minute, w.day_mask};
            fill++;
          end
        end
        REQ_DEL: begin
          if (w.entry_index >= fill) begin
            r.status = ST_RANGE;
            ranges++;
          end else begin
            for (int i = w.entry_index; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
          end
        end
        default: begin
          if (w.entry_index >= fill) begin
            r.status = ST_RANGE;
            ranges++;
          end else begin
            r.read_hour   = slots[w.entry_index].hour;
            r.read_minute = slots[w.entry_index].minute;
            r.read_mask   = slots[w.entry_index].mask;
          end
        end
      endcase
      r.alarm_count = CNT_OUT_W'(fill);
      pending.push_back(r);
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("reply word with nothing outstanding: %h", got);
        mismatches++;
      end else begin
        want = pending.pop_front();
        replies++;
        match_field("status", want.status, got.status);
        match_field("alarm_hit", want.alarm_hit, got.alarm_hit);
        match_field("checked_index", want.checked_index, got.checked_index);
        match_field("alarm_count", want.alarm_count, got.alarm_count);
        match_field("read_hour", want.read_hour, got.read_hour);
        match_field("read_minute", want.read_minute, got.read_minute);
        match_field("read_mask", want.read_mask, got.read_mask);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_word_o;

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 45;
  int unsigned stall_cycles  = 0;

  alarm_table_tracker alarms = new();

  weekday_alarm_table_matcher_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("handshake stall for %0d cycles", STALL_LIMIT);
    $display("** weekday_alarm_table_matcher_unit: FAILED **");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) alarms.check_result(out_word_o);
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input in_word_t w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    alarms.note_request(w);
  endtask

  task automatic issue_request(input req_e req, input int h, input int m, input int s,
                               input int wd, input int mask, input int idx);
    in_word_t w;
    w.req_type    = req;
    w.hour        = 5'(h);
    w.minute      = 6'(m);
    w.second      = 6'(s);
    w.weekday     = 3'(wd);
    w.day_mask    = 7'(mask);
    w.entry_index = 6'(idx);
    send_request(w);
  endtask

  function automatic in_word_t make_request(burst_e shape);
    in_word_t    w;
    int unsigned pick;
    int unsigned d;
    entry_t      target;
    w.req_type    = 2'($urandom);
    w.hour        = 5'($urandom);
    w.minute      = 6'($urandom);
    w.second      = 6'($urandom);
    w.weekday     = 3'($urandom);
    w.day_mask    = 7'($urandom);
    w.entry_index = 6'($urandom);
    pick = $urandom_range(0, 99);
    case (shape)
      FILL_BURST:
        w.req_type = pick < 55 ? REQ_ADD : pick < 80 ? REQ_CHECK : pick < 92 ? REQ_READ : REQ_DEL;
      DRAIN_BURST:
        w.req_type = pick < 45 ? REQ_DEL : pick < 70 ? REQ_CHECK : pick < 85 ? REQ_READ : REQ_ADD;
      default: ;
    endcase
    if (w.req_type == REQ_ADD && $urandom_range(0, 9) != 0) begin
      w.hour   = 5'($urandom_range(0, 23));
      w.minute = 6'($urandom_range(0, 59));
    end
    if ((w.req_type == REQ_DEL || w.req_type == REQ_READ) && alarms.fill > 0 &&
        $urandom_range(0, 4) != 0) begin
      w.entry_index = 6'($urandom_range(0, alarms.fill - 1));
    end
    if (w.req_type == REQ_CHECK && alarms.fill > 0 && $urandom_range(0, 9) < 6) begin
      target   = alarms.slots[alarms.next_scan()];
      w.hour   = target.hour;
      w.minute = target.minute;
      if (target.mask != '0 && $urandom_range(0, 1) == 1) begin
        d = $urandom_range(0, 6);
        while (!target.mask[d]) d = $urandom_range(0, 6);
        w.weekday = (d == 6 && $urandom_range(0, 1) == 1) ? 3'd0 : 3'(d + 1);
      end
    end
    return w;
  endfunction

  initial begin
    burst_e      shape;
    int unsigned sent;
    int unsigned burst_len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    issue_request(REQ_CHECK, 0, 0, 2, 0, 127, 0);
    issue_request(REQ_READ, 31, 63, 63, 7, 127, 0);
    issue_request(REQ_DEL, 0, 0, 0, 0, 0, 63);
    // extremes of the entry fields, out-of-range time values too
    issue_request(REQ_ADD, 0, 0, 63, 7, 127, 63);
    issue_request(REQ_ADD, 23, 59, 0, 0, 1, 0);
    issue_request(REQ_ADD, 31, 63, 17, 5, 64, 42);
    issue_request(REQ_ADD, 12, 30, 30, 3, 0, 21);
    for (int i = 0; i < 5; i++) issue_request(REQ_READ, 0, 0, 0, 0, 0, i);
    // round-robin checks: seconds gate, saturday wrap, empty mask
    issue_request(REQ_CHECK, 0, 0, 2, 1, 0, 0);
    issue_request(REQ_CHECK, 23, 59, 59, 1, 0, 0);
    issue_request(REQ_CHECK, 31, 63, 63, 0, 0, 0);
    issue_request(REQ_CHECK, 12, 30, 30, 3, 0, 0);
    issue_request(REQ_CHECK, 0, 0, 1, 7, 0, 0);
    issue_request(REQ_CHECK, 23, 59, 0, 1, 0, 0);
    // deletes in the middle, at the end and at the front, scan past the end
    issue_request(REQ_DEL, 0, 0, 0, 0, 0, 1);
    issue_request(REQ_DEL, 0, 0, 0, 0, 0, 2);
    issue_request(REQ_DEL, 0, 0, 0, 0, 0, 0);
    issue_request(REQ_READ, 0, 0, 0, 0, 0, 0);
    issue_request(REQ_CHECK, 31, 63, 2, 7, 0, 0);
    issue_request(REQ_DEL, 0, 0, 0, 0, 0, 0);
    issue_request(REQ_ADD, 7, 45, 0, 0, 42, 0);

    shape = FILL_BURST;
    for (int load = 0; load < 3; load++) begin
      case (load)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_LOAD) begin
        burst_len = $urandom_range(100, 200);
        for (int k = 0; k < burst_len && sent < ITEMS_PER_LOAD; k++) begin
          send_request(make_request(shape));
          sent++;
        end
        shape = shape.next();
      end
    end

    in_valid_i <= 1'b0;
    while (alarms.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests under three idling patterns, table filled to capacity and drained",
             alarms.requests);
    $display("%0d replies checked: %0d alarm hits, %0d adds on a full table, %0d index errors",
             alarms.replies, alarms.hits, alarms.fulls, alarms.ranges);
    if (alarms.mismatches == 0) begin
      $display("** weekday_alarm_table_matcher_unit: PASSED **");
    end else begin
      $display("** weekday_alarm_table_matcher_unit: FAILED **");
    end
    $finish;
  end

endmodule
